// File: design/qac_pkg.sv
// Shared types and codes for the quaternion alignment calibrator.
// No dependencies; imported by the top level and its port checker.
`default_nettype none

package qac_pkg;

  localparam int COMP_W = 16;

  // Quaternion with w in the lowest bits, matching the stream packing.
  typedef struct packed {
    logic signed [COMP_W-1:0] z;
    logic signed [COMP_W-1:0] y;
    logic signed [COMP_W-1:0] x;
    logic signed [COMP_W-1:0] w;
  } quat_t;

  typedef enum logic {
    OP_CAL   = 1'b0,
    OP_APPLY = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNCAL = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

endpackage

`default_nettype wire

// File: design/quaternion_alignment_calibrator_top.sv
// Quaternion alignment calibrator top level: input register, Hamilton product,
// result register and the per-sensor alignment table. Depends on qac_pkg.
//
// Takes one item per clock while the result side is not stalled and returns one result
// per item. Each item passes the input register and then the result register, and a
// stalled result holds the next item in the input register. The rate is set by the
// single compute stage: sixteen 17x16 products, a four-term sum, rounding and
// saturation between the input register and the result register. The alignment
// table is read and written in that stage, so an apply right behind a calibrate
// of the same sensor sees the new alignment. The table needs no clearing after
// reset; only the calibrated flags are cleared.
`default_nettype none

module quaternion_alignment_calibrator_top
  import qac_pkg::*;
#(
  parameter int SENSORS   = 4,
  parameter int FRAC_BITS = 14
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // config: active sensor count
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_wdata,
  // input stream
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,   // meas_w, meas_x, meas_y, meas_z, ref_w, ref_x, ref_y, ref_z
  input  wire logic [2:0]   in_tuser,   // op, sensor[1:0]
  // result stream
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [63:0]       out_tdata,  // out_w, out_x, out_y, out_z
  output logic [1:0]        out_tuser   // status[1:0]
);

  localparam int IDX_W = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam logic [4:0] SENS_LIM = 5'(SENSORS);
  localparam logic signed [35:0] RND = 36'sd1 <<< (FRAC_BITS - 1);
  localparam logic [2:0] ACTIVE_RST = 3'd4;

  // configuration
  logic [2:0] active_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_RST;
    end else if (cfg_we) begin
      active_r <= cfg_wdata;
    end
  end

  // input register
  logic       s1_v_r;
  op_t        s1_op_r;
  logic [1:0] s1_sens_r;
  quat_t      s1_meas_r;
  quat_t      s1_ref_r;
  logic       adv;

  assign in_tready = !s1_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_op_r   <= op_t'(in_tuser[0]);
      s1_sens_r <= in_tuser[2:1];
      s1_meas_r <= quat_t'(in_tdata[63:0]);
      s1_ref_r  <= quat_t'(in_tdata[127:64]);
    end
  end

  // alignment table and calibrated flags
  quat_t            tbl_r [SENSORS];
  logic [SENSORS-1:0] cal_r;

  logic [IDX_W-1:0] idx;
  logic             in_rng;
  logic             wr_en;

  assign idx    = IDX_W'(s1_sens_r);
  assign in_rng = ({3'b000, s1_sens_r} < {2'b00, active_r}) &&
                  ({3'b000, s1_sens_r} < SENS_LIM);
  assign wr_en  = adv && in_rng && (s1_op_r == OP_CAL);

  // round to nearest (ties up), then saturate to 16 bits
  function automatic logic signed [15:0] rsat(input logic signed [35:0] s);
    logic signed [35:0] t;
    t = (s + RND) >>> FRAC_BITS;
    if (t > 36'sd32767) begin
      rsat = 16'sh7fff;
    end else if (t < -36'sd32768) begin
      rsat = 16'sh8000;
    end else begin
      rsat = t[15:0];
    end
  endfunction

  function automatic quat_t ham(
    input logic signed [16:0] pw, input logic signed [16:0] px,
    input logic signed [16:0] py, input logic signed [16:0] pz,
    input logic signed [15:0] qw, input logic signed [15:0] qx,
    input logic signed [15:0] qy, input logic signed [15:0] qz
  );
    logic signed [35:0] sw, sx, sy, sz;
    quat_t r;
    sw = pw * qw - px * qx - py * qy - pz * qz;
    sx = pw * qx + px * qw + py * qz - pz * qy;
    sy = pw * qy - px * qz + py * qw + pz * qx;
    sz = pw * qz + px * qy - py * qx + pz * qw;
    r.w = rsat(sw);
    r.x = rsat(sx);
    r.y = rsat(sy);
    r.z = rsat(sz);
    ham = r;
  endfunction

  // compute stage
  quat_t              al;
  logic               cal;
  logic signed [16:0] pw, px, py, pz;
  quat_t              q;
  quat_t              prod;
  status_t            st;

  assign al  = tbl_r[idx];
  assign cal = cal_r[idx];

  always_comb begin
    if (s1_op_r == OP_APPLY) begin
      pw = {al.w[15], al.w};
      px = {al.x[15], al.x};
      py = {al.y[15], al.y};
      pz = {al.z[15], al.z};
      q  = s1_meas_r;
    end else begin
      // conjugate of the measurement; 17 bits keep -(-32768) exact
      pw = {s1_meas_r.w[15], s1_meas_r.w};
      px = -{s1_meas_r.x[15], s1_meas_r.x};
      py = -{s1_meas_r.y[15], s1_meas_r.y};
      pz = -{s1_meas_r.z[15], s1_meas_r.z};
      q  = s1_ref_r;
    end
  end

  assign prod = ham(pw, px, py, pz, q.w, q.x, q.y, q.z);

  always_comb begin
    if (!in_rng) begin
      st = ST_RANGE;
    end else if ((s1_op_r == OP_APPLY) && !cal) begin
      st = ST_UNCAL;
    end else begin
      st = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl_r[idx] <= prod;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else if (wr_en) begin
      cal_r[idx] <= 1'b1;
    end
  end

  // result register
  logic    out_v_r;
  quat_t   out_q_r;
  status_t out_st_r;

  assign adv = s1_v_r && (!out_v_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_q_r  <= (st == ST_OK) ? prod : '0;
      out_st_r <= st;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_q_r;
  assign out_tuser  = out_st_r;

endmodule

`default_nettype wire

// File: design/qac_checker.sv
// Port-level checker for the quaternion alignment calibrator, bound to the top.
// Depends on qac_pkg for the status codes.
`default_nettype none

module qac_checker
  import qac_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata,
  input wire logic [1:0]  out_tuser
);

  // no status code outside the defined set
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_OK || out_tuser == ST_UNCAL || out_tuser == ST_RANGE))
    else $error("undefined status code on result");

  // error results carry a zero quaternion
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_OK) |-> (out_tdata == 64'd0))
    else $error("error result with nonzero quaternion");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind quaternion_alignment_calibrator_top qac_checker u_qac_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
